[src/rtfd_pkg.sv]
`default_nettype none

package rtfd_pkg;

    localparam int FRAME_BYTES  = 32;
    localparam int RECORD_BYTES = 28;
    localparam int POS_W        = $clog2(FRAME_BYTES);
    localparam int REC_IDX_W    = 5;
    localparam int TABLE_ADDR_W = 13;
    localparam int OFFSET_W     = 5;
    localparam int HEAD_READS   = 16;

    localparam logic [4:0] OFFSET_RESET = 5'd8;

    localparam logic [7:0] HDR_BYTE   = 8'h43;
    localparam logic [7:0] TRL_BYTE   = 8'h34;
    localparam logic [7:0] ASCII_ZERO = 8'h30;
    localparam logic [7:0] MODE_TIME  = 8'd1;
    localparam logic [7:0] MODE_TABLE = 8'd2;
    localparam logic [7:0] MODE_REPLY = 8'd4;
    localparam logic [7:0] GPS_LOCKED = 8'd1;

    localparam logic [POS_W-1:0] BYTE_HDR   = POS_W'(0);
    localparam logic [POS_W-1:0] BYTE_MODE  = POS_W'(1);
    localparam logic [POS_W-1:0] BYTE_REPLY = POS_W'(15);
    localparam logic [POS_W-1:0] BYTE_GPS   = POS_W'(30);
    localparam logic [POS_W-1:0] BYTE_LAST  = POS_W'(FRAME_BYTES - 1);
    localparam logic [POS_W-1:0] BYTE_TABLE = POS_W'(3);

    localparam logic [3:0] STEP_HDR   = 4'd0;
    localparam logic [3:0] STEP_MODE  = 4'd1;
    localparam logic [3:0] STEP_GPS   = 4'd2;
    localparam logic [3:0] STEP_REPLY = 4'd3;
    localparam logic [3:0] STEP_REC   = 4'd4;
    localparam logic [3:0] STEP_HOUR  = 4'd5;
    localparam logic [3:0] STEP_MIN   = 4'd7;
    localparam logic [3:0] STEP_SEC   = 4'd9;
    localparam logic [3:0] STEP_DAY   = 4'd11;
    localparam logic [3:0] STEP_MONTH = 4'd13;
    localparam logic [3:0] STEP_YEAR  = 4'd15;

    localparam logic [2:0] KIND_TIME   = 3'd0;
    localparam logic [2:0] KIND_NOSIG  = 3'd1;
    localparam logic [2:0] KIND_TABLE  = 3'd2;
    localparam logic [2:0] KIND_REPLY  = 3'd3;
    localparam logic [2:0] KIND_FAULT  = 3'd4;

    localparam logic [7:0]  HOURS_PER_DAY = 8'd24;
    localparam logic [7:0]  MONTHS        = 8'd12;
    localparam logic [15:0] BASE_YEAR     = 16'd2000;

    localparam logic [14:0] CENT_RECIP = 15'd20972;
    localparam int          CENT_SHIFT = 19;

    typedef struct packed {
        logic [7:0] frame_byte;
        logic       frame_start;
    } frame_t;

    typedef struct packed {
        logic [2:0]              result_kind;
        logic [15:0]             year;
        logic [7:0]              month;
        logic [7:0]              day;
        logic [4:0]              hour;
        logic [7:0]              minute;
        logic [7:0]              second;
        logic [TABLE_ADDR_W-1:0] table_address;
        logic [7:0]              table_data;
        logic                    last;
    } result_t;

    typedef struct packed {
        logic [7:0]  hour_sum;
        logic [7:0]  minute;
        logic [7:0]  second;
        logic [7:0]  day;
        logic [7:0]  month;
        logic [15:0] year;
        logic        leap;
    } time_raw_t;

    function automatic logic [POS_W-1:0] head_addr(input logic [3:0] step);
        logic [POS_W-1:0] addr;
        unique case (step)
            STEP_HDR:   addr = BYTE_HDR;
            STEP_MODE:  addr = BYTE_MODE;
            STEP_GPS:   addr = BYTE_GPS;
            STEP_REPLY: addr = BYTE_REPLY;
            default:    addr = POS_W'(step) - POS_W'(2);
        endcase
        return addr;
    endfunction

    function automatic logic is_leap(input logic [15:0] y);
        logic [13:0] x;
        logic [28:0] prod;
        logic [9:0]  q;
        logic [15:0] back;
        x    = y[15:2];
        prod = 29'(x) * 29'(CENT_RECIP);
        q    = prod[28:CENT_SHIFT];
        back = 16'(q) * 16'd100;
        return (back == y) ? (q[1:0] == 2'b00) : (y[1:0] == 2'b00);
    endfunction

    function automatic logic [4:0] mod24(input logic [7:0] h);
        logic [4:0] x;
        logic [8:0] p;
        logic [3:0] q;
        logic [7:0] r;
        x = h[7:3];
        p = 9'(x) * 9'd11;
        q = p[8:5];
        r = h - 8'(q) * HOURS_PER_DAY;
        return r[4:0];
    endfunction

    function automatic logic [7:0] month_length(input logic [7:0] m, input logic leap);
        logic [7:0] len;
        unique case (m)
            8'd2:                    len = leap ? 8'd29 : 8'd28;
            8'd4, 8'd6, 8'd9, 8'd11: len = 8'd30;
            default:                 len = 8'd31;
        endcase
        return len;
    endfunction

endpackage

`default_nettype wire

[src/rtfd_time_calc.sv]
`default_nettype none

module rtfd_time_calc (
    input  rtfd_pkg::time_raw_t raw,
    output rtfd_pkg::result_t   res
);
    import rtfd_pkg::*;

    logic       wrap;
    logic [7:0] day_inc;
    logic [7:0] month_inc;
    logic       carry_m;
    logic       carry_y;

    always_comb
    begin
        wrap      = (raw.hour_sum >= HOURS_PER_DAY);
        day_inc   = raw.day + 8'd1;
        month_inc = raw.month + 8'd1;
        carry_m   = (day_inc > month_length(raw.month, raw.leap));
        carry_y   = (month_inc > MONTHS);

        res             = '0;
        res.result_kind = KIND_TIME;
        res.last        = 1'b1;
        res.minute      = raw.minute;
        res.second      = raw.second;
        res.hour        = raw.hour_sum[4:0];
        res.day         = raw.day;
        res.month       = raw.month;
        res.year        = raw.year;
        if (wrap)
        begin
            res.hour = mod24(raw.hour_sum);
            res.day  = day_inc;
            if (carry_m)
            begin
                res.day   = 8'd1;
                res.month = month_inc;
                if (carry_y)
                begin
                    res.month = 8'd1;
                    res.year  = raw.year + 16'd1;
                end
            end
        end
    end

endmodule

`default_nettype wire

[src/radio_time_frame_decoder_unit.sv]
`default_nettype none

// Channel   Direction  Handshake                 Payload
// frame     in         frame_valid/frame_stall   rtfd_pkg::frame_t
// result    out        result_valid/result_stall rtfd_pkg::result_t
// cfg       in         cfg_valid/cfg_ready       utc_offset_hours (5 bits)
//
// Bytes 0..30 of a frame take one cycle each while frame is not stalled and write the frame RAM.
// The closing byte starts a header scan over the single RAM read port; a time
// result passes S_LEAP and S_CALC, each table write passes S_TREAD and S_TOUT.
// frame is stalled from the closing byte until the last result is loaded (a reply
// frame with a zero reply byte loads none). Reset clears the byte position, sequencer
// and result valid and sets the offset to 8; the frame RAM is not cleared.

module radio_time_frame_decoder_unit (
    input  wire                       clk,
    input  wire                       rst_n,
    input  wire                       frame_valid,
    output logic                      frame_stall,
    input  rtfd_pkg::frame_t          frame,
    output logic                      result_valid,
    input  wire                       result_stall,
    output rtfd_pkg::result_t         result,
    input  wire                       cfg_valid,
    output logic                      cfg_ready,
    input  wire [rtfd_pkg::OFFSET_W-1:0] cfg_data
);
    import rtfd_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_HEAD  = 7'b0000010,
        S_LEAP  = 7'b0000100,
        S_CALC  = 7'b0001000,
        S_EMIT  = 7'b0010000,
        S_TREAD = 7'b0100000,
        S_TOUT  = 7'b1000000
    } state_t;

    state_t                state_reg, state_next;
    logic [4:0]            seq_reg, seq_next;
    logic [REC_IDX_W-1:0]  k_reg, k_next;
    logic [POS_W-1:0]      pos_reg, pos_next;
    logic [OFFSET_W-1:0]   offset_reg, offset_next;
    logic [2:0]            kind_reg, kind_next;
    logic                  result_valid_reg, result_valid_next;
    result_t               result_reg;

    logic [7:0]            frame_mem [FRAME_BYTES];
    logic [7:0]            rd_data_reg;
    logic [POS_W-1:0]      rd_addr;
    logic [POS_W-1:0]      wpos;

    logic [7:0]  f0_reg, f1_reg, f30_reg, f31_reg, rec_reg;
    logic        reply_nz_reg;
    logic [15:0] hi16_reg;
    logic [7:0]  hour_sum_reg, minute_reg, second_reg, day_reg, month_reg;
    logic [15:0] year_reg;
    logic        leap_reg;

    logic        frame_accept;
    logic        out_free;
    logic        out_load;
    result_t     out_next;
    logic [3:0]  item;
    logic [15:0] digit16;
    logic [7:0]  pair8;
    logic        head_done;
    time_raw_t   raw;
    result_t     time_res;

    assign frame_stall  = (state_reg != S_IDLE);
    assign frame_accept = frame_valid && !frame_stall;
    assign cfg_ready    = 1'b1;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;
    assign out_free     = !result_valid_reg || !result_stall;

    assign wpos      = frame.frame_start ? BYTE_HDR : pos_reg;
    assign item      = 4'(seq_reg - 5'd1);
    assign head_done = (seq_reg == 5'(HEAD_READS));
    assign digit16   = {8'h00, rd_data_reg} - {8'h00, ASCII_ZERO};
    assign pair8     = hi16_reg[7:0] * 8'd10 + rd_data_reg - ASCII_ZERO;

    always_comb
    begin
        if (state_reg == S_TREAD || state_reg == S_TOUT)
            rd_addr = k_reg + BYTE_TABLE;
        else
            rd_addr = head_addr(seq_reg[3:0]);
    end

    always_ff @(posedge clk)
    begin
        if (frame_accept)
            frame_mem[wpos] <= frame.frame_byte;
        rd_data_reg <= frame_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (frame_accept && wpos == BYTE_LAST)
            f31_reg <= frame.frame_byte;
        if (state_reg == S_HEAD && seq_reg != 5'd0)
        begin
            unique case (item)
                STEP_HDR:   f0_reg <= rd_data_reg;
                STEP_MODE:  f1_reg <= rd_data_reg;
                STEP_GPS:   f30_reg <= rd_data_reg;
                STEP_REPLY: reply_nz_reg <= (rd_data_reg != 8'd0);
                STEP_REC:
                begin
                    rec_reg  <= rd_data_reg;
                    hi16_reg <= digit16;
                end
                STEP_HOUR:  hour_sum_reg <= pair8 + {3'b000, offset_reg};
                STEP_MIN:   minute_reg <= pair8;
                STEP_SEC:   second_reg <= pair8;
                STEP_DAY:   day_reg <= pair8;
                STEP_MONTH: month_reg <= pair8;
                STEP_YEAR:  year_reg <= BASE_YEAR + hi16_reg * 16'd10 + digit16;
                default:    hi16_reg <= digit16;
            endcase
        end
        if (state_reg == S_LEAP)
            leap_reg <= is_leap(year_reg);
        if (out_load)
            result_reg <= out_next;
    end

    always_comb
    begin
        raw.hour_sum = hour_sum_reg;
        raw.minute   = minute_reg;
        raw.second   = second_reg;
        raw.day      = day_reg;
        raw.month    = month_reg;
        raw.year     = year_reg;
        raw.leap     = leap_reg;
    end

    rtfd_time_calc u_time_calc (
        .raw (raw),
        .res (time_res)
    );

    always_comb
    begin
        state_next        = state_reg;
        seq_next          = seq_reg;
        k_next            = k_reg;
        pos_next          = pos_reg;
        offset_next       = offset_reg;
        kind_next         = kind_reg;
        out_load          = 1'b0;
        out_next          = '0;

        if (cfg_valid && cfg_ready)
            offset_next = cfg_data;

        if (frame_accept)
        begin
            if (wpos == BYTE_LAST)
                pos_next = BYTE_HDR;
            else
                pos_next = wpos + POS_W'(1);
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (frame_accept && wpos == BYTE_LAST)
                begin
                    seq_next   = 5'd0;
                    state_next = S_HEAD;
                end
            end
            S_HEAD:
            begin
                seq_next = seq_reg + 5'd1;
                if (head_done)
                begin
                    priority if (f0_reg != HDR_BYTE || f31_reg != TRL_BYTE)
                    begin
                        kind_next  = KIND_FAULT;
                        state_next = S_EMIT;
                    end
                    else if (f1_reg == MODE_TIME)
                    begin
                        if (f30_reg == GPS_LOCKED)
                            state_next = S_LEAP;
                        else
                        begin
                            kind_next  = KIND_NOSIG;
                            state_next = S_EMIT;
                        end
                    end
                    else if (f1_reg == MODE_TABLE)
                    begin
                        k_next     = '0;
                        state_next = S_TREAD;
                    end
                    else if (f1_reg == MODE_REPLY)
                    begin
                        if (reply_nz_reg)
                        begin
                            kind_next  = KIND_REPLY;
                            state_next = S_EMIT;
                        end
                        else
                            state_next = S_IDLE;
                    end
                    else
                    begin
                        kind_next  = KIND_FAULT;
                        state_next = S_EMIT;
                    end
                end
            end
            S_LEAP:
                state_next = S_CALC;
            S_CALC:
            begin
                if (out_free)
                begin
                    out_load   = 1'b1;
                    out_next   = time_res;
                    state_next = S_IDLE;
                end
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    out_load             = 1'b1;
                    out_next.result_kind = kind_reg;
                    out_next.last        = 1'b1;
                    state_next           = S_IDLE;
                end
            end
            S_TREAD:
                state_next = S_TOUT;
            S_TOUT:
            begin
                if (out_free)
                begin
                    out_load               = 1'b1;
                    out_next.result_kind   = KIND_TABLE;
                    out_next.table_address = TABLE_ADDR_W'(rec_reg) * TABLE_ADDR_W'(RECORD_BYTES)
                                             + TABLE_ADDR_W'(k_reg);
                    out_next.table_data    = rd_data_reg;
                    out_next.last          = (k_reg == REC_IDX_W'(RECORD_BYTES - 1));
                    if (out_next.last)
                        state_next = S_IDLE;
                    else
                    begin
                        k_next     = k_reg + REC_IDX_W'(1);
                        state_next = S_TREAD;
                    end
                end
            end
            default:
                state_next = S_IDLE;
        endcase

        if (out_load)
            result_valid_next = 1'b1;
        else if (!result_stall)
            result_valid_next = 1'b0;
        else
            result_valid_next = result_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            seq_reg          <= '0;
            k_reg            <= '0;
            pos_reg          <= '0;
            offset_reg       <= OFFSET_RESET;
            kind_reg         <= KIND_FAULT;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            seq_reg          <= seq_next;
            k_reg            <= k_next;
            pos_reg          <= pos_next;
            offset_reg       <= offset_next;
            kind_reg         <= kind_next;
            result_valid_reg <= result_valid_next;
        end
    end

    a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(state_reg))
        else $error("sequencer state not one-hot");

    a_more_follows: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.last |-> state_reg != S_IDLE)
        else $error("non-final transfer pending with sequencer idle");

    a_hour_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.result_kind == KIND_TIME |-> result.hour < HOURS_PER_DAY[4:0])
        else $error("local hour out of range");

    a_scan_start: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_HEAD && seq_reg == 5'd0 |-> $past(frame_accept))
        else $error("header scan started without a closing byte");

endmodule

`default_nettype wire
